/* src/mcoc_pkg.sv */
// shared types, sizes and helpers for the matrix chain order cost block
// no dependencies
package mcoc_pkg;

    // largest chain held at once
    localparam int MAX_MATRICES = 64;

    localparam int DIM_W     = 16;
    localparam int COST_W    = 56;
    localparam int PIJ_W     = 2 * DIM_W;
    localparam int PROD_W    = 3 * DIM_W;
    localparam int IDX_W     = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
    localparam int CNT_W     = $clog2(MAX_MATRICES + 1);
    localparam int DIM_DEPTH = MAX_MATRICES + 1;
    localparam int DIM_AW    = $clog2(DIM_DEPTH);
    localparam int COST_DEPTH = MAX_MATRICES * MAX_MATRICES;
    localparam int COST_AW   = $clog2(COST_DEPTH);

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [DIM_AW-1:0]  t_dim_addr;
    typedef logic [COST_AW-1:0] t_cost_addr;
    typedef logic [DIM_W-1:0]   t_dim;
    typedef logic [COST_W-1:0]  t_cost;

    typedef struct packed {
        logic [15:0] row_count;
        logic [15:0] col_count;
        logic        last_matrix;
    } t_in_word;

    typedef struct packed {
        logic [55:0] min_cost;
        logic        chain_error;
    } t_out_word;

    // sequencer status toward the top level
    typedef struct packed {
        logic  busy;
        logic  done;
        t_cost cost;
    } t_seq_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PI,
        S_PJ,
        S_PIJ,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_seq_state;

    // flat address of interval (row, col)
    function automatic t_cost_addr cost_addr(input t_idx row, input t_idx col);
        return t_cost_addr'(row) * t_cost_addr'(MAX_MATRICES) + t_cost_addr'(col);
    endfunction

    // saturating add of two costs
    function automatic t_cost sat_add(input t_cost a, input t_cost b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

endpackage

/* src/mcoc_dim_mem.sv */
// dimension vector memory, one write port, one registered read port
// depends on mcoc_pkg
module mcoc_dim_mem (
    input  logic               i_clk,
    input  logic               i_we,
    input  mcoc_pkg::t_dim_addr i_waddr,
    input  mcoc_pkg::t_dim     i_wdata,
    input  mcoc_pkg::t_dim_addr i_raddr,
    output mcoc_pkg::t_dim     o_rdata
);

    mcoc_pkg::t_dim r_mem [mcoc_pkg::DIM_DEPTH];
    mcoc_pkg::t_dim r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

/* src/mcoc_cost_mem.sv */
// interval cost table, one write port and two registered read ports
// depends on mcoc_pkg
module mcoc_cost_mem (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  mcoc_pkg::t_cost_addr i_waddr,
    input  mcoc_pkg::t_cost      i_wdata,
    input  mcoc_pkg::t_cost_addr i_raddr_a,
    input  mcoc_pkg::t_cost_addr i_raddr_b,
    output mcoc_pkg::t_cost      o_rdata_a,
    output mcoc_pkg::t_cost      o_rdata_b
);

    mcoc_pkg::t_cost r_mem [mcoc_pkg::COST_DEPTH];
    mcoc_pkg::t_cost r_qa;
    mcoc_pkg::t_cost r_qb;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports
    always_ff @(posedge i_clk) begin
        r_qa <= r_mem[i_raddr_a];
        r_qb <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_qa;
    assign o_rdata_b = r_qb;

endmodule

/* src/mcoc_seq.sv */
// interval table sequencer with the split-point cost pipeline
// depends on mcoc_pkg; drives the dimension and cost memories
module mcoc_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  mcoc_pkg::t_cnt        i_n,
    input  mcoc_pkg::t_dim        i_p0,
    input  logic                  i_take,
    output mcoc_pkg::t_seq_stat   o_stat,
    output mcoc_pkg::t_dim_addr   o_dim_raddr,
    input  mcoc_pkg::t_dim        i_dim_q,
    output logic                  o_cost_we,
    output mcoc_pkg::t_cost_addr  o_cost_waddr,
    output mcoc_pkg::t_cost       o_cost_wdata,
    output mcoc_pkg::t_cost_addr  o_cost_raddr_a,
    output mcoc_pkg::t_cost_addr  o_cost_raddr_b,
    input  mcoc_pkg::t_cost       i_cost_qa,
    input  mcoc_pkg::t_cost       i_cost_qb
);

    mcoc_pkg::t_seq_state r_state;
    mcoc_pkg::t_seq_state n_state;

    mcoc_pkg::t_cnt r_n;
    mcoc_pkg::t_cnt r_len;
    mcoc_pkg::t_idx r_i;
    mcoc_pkg::t_idx r_k;

    mcoc_pkg::t_dim                    r_pi;
    logic [mcoc_pkg::PIJ_W-1:0]        r_pij;
    logic                              r_v1;
    logic                              r_za;
    logic                              r_zb;
    logic                              r_v2;
    logic [mcoc_pkg::PROD_W-1:0]       r_prod;
    mcoc_pkg::t_cost                   r_sum;
    mcoc_pkg::t_cost                   r_best;

    mcoc_pkg::t_cnt j_full;
    mcoc_pkg::t_idx j_idx;
    mcoc_pkg::t_idx k_next;
    logic           last_k;
    logic           last_i;
    logic           pipe_empty;
    logic           issue;
    mcoc_pkg::t_cost term_a;
    mcoc_pkg::t_cost term_b;
    mcoc_pkg::t_cost cand;

    // interval bounds
    assign j_full     = mcoc_pkg::t_cnt'(r_i) + r_len - mcoc_pkg::t_cnt'(1);
    assign j_idx      = j_full[mcoc_pkg::IDX_W-1:0];
    assign k_next     = r_k + mcoc_pkg::t_idx'(1);
    assign last_k     = (mcoc_pkg::t_cnt'(r_k) + mcoc_pkg::t_cnt'(1)) == j_full;
    assign last_i     = (mcoc_pkg::t_cnt'(r_i) + r_len) == r_n;
    assign pipe_empty = !r_v1 && !r_v2;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcoc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_n == mcoc_pkg::t_cnt'(1)) ? mcoc_pkg::S_DONE
                                                           : mcoc_pkg::S_PI;
                end
            end
            mcoc_pkg::S_PI:  n_state = mcoc_pkg::S_PJ;
            mcoc_pkg::S_PJ:  n_state = mcoc_pkg::S_PIJ;
            mcoc_pkg::S_PIJ: n_state = mcoc_pkg::S_RUN;
            mcoc_pkg::S_RUN: begin
                if (last_k) begin
                    n_state = mcoc_pkg::S_DRAIN;
                end
            end
            mcoc_pkg::S_DRAIN: begin
                if (pipe_empty) begin
                    n_state = (last_i && r_len == r_n) ? mcoc_pkg::S_DONE
                                                        : mcoc_pkg::S_PI;
                end
            end
            mcoc_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = mcoc_pkg::S_IDLE;
                end
            end
            default: n_state = mcoc_pkg::S_IDLE;
        endcase
    end

    // outputs and memory addressing
    always_comb begin
        issue        = 1'b0;
        o_cost_we    = 1'b0;
        o_dim_raddr  = mcoc_pkg::t_dim_addr'(k_next);
        case (r_state)
            mcoc_pkg::S_PI:    o_dim_raddr = mcoc_pkg::t_dim_addr'(r_i);
            mcoc_pkg::S_PJ:    o_dim_raddr = mcoc_pkg::t_dim_addr'(j_full)
                                             + mcoc_pkg::t_dim_addr'(1);
            mcoc_pkg::S_RUN:   issue = 1'b1;
            mcoc_pkg::S_DRAIN: o_cost_we = pipe_empty;
            default:           issue = 1'b0;
        endcase
    end

    assign o_cost_raddr_a = mcoc_pkg::cost_addr(r_i, r_k);
    assign o_cost_raddr_b = mcoc_pkg::cost_addr(k_next, j_idx);
    assign o_cost_waddr   = mcoc_pkg::cost_addr(r_i, j_idx);
    assign o_cost_wdata   = r_best;

    assign o_stat.busy = (r_state != mcoc_pkg::S_IDLE);
    assign o_stat.done = (r_state == mcoc_pkg::S_DONE);
    assign o_stat.cost = r_best;

    // diagonal entries read as zero
    assign term_a = r_za ? '0 : i_cost_qa;
    assign term_b = r_zb ? '0 : i_cost_qb;
    assign cand   = mcoc_pkg::sat_add(r_sum, mcoc_pkg::t_cost'(r_prod));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcoc_pkg::S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
        end
    end

    // loop counters
    always_ff @(posedge i_clk) begin
        case (r_state)
            mcoc_pkg::S_IDLE: begin
                r_n   <= i_n;
                r_len <= mcoc_pkg::t_cnt'(2);
                r_i   <= '0;
            end
            mcoc_pkg::S_PIJ: r_k <= r_i;
            mcoc_pkg::S_RUN: r_k <= k_next;
            mcoc_pkg::S_DRAIN: begin
                if (pipe_empty) begin
                    if (last_i) begin
                        r_i   <= '0;
                        r_len <= r_len + mcoc_pkg::t_cnt'(1);
                    end else begin
                        r_i <= r_i + mcoc_pkg::t_idx'(1);
                    end
                end
            end
            default: r_k <= r_k;
        endcase
    end

    // dimension products and split-point pipeline
    always_ff @(posedge i_clk) begin
        if (r_state == mcoc_pkg::S_PJ) begin
            r_pi <= (r_i == '0) ? i_p0 : i_dim_q;
        end
        if (r_state == mcoc_pkg::S_PIJ) begin
            r_pij <= r_pi * i_dim_q;
        end
        r_za   <= (r_k == r_i);
        r_zb   <= last_k;
        r_prod <= r_pij * i_dim_q;
        r_sum  <= mcoc_pkg::sat_add(term_a, term_b);
        if (r_state == mcoc_pkg::S_IDLE) begin
            r_best <= '0;
        end else if (r_state == mcoc_pkg::S_PIJ) begin
            r_best <= mcoc_pkg::COST_MAX;
        end else if (r_v2 && cand < r_best) begin
            r_best <= cand;
        end
    end

endmodule

/* src/matrix_chain_order_cost_core.sv */
// Minimum matrix chain multiplication cost. Matrices arrive one word each
// (rows, columns, last flag); the dimension vector goes to a small memory
// and the last word starts a fill of the interval cost table held in a
// 1-write, 2-read memory. Each interval (i, j) passes through the setup
// states S_PI, S_PJ and S_PIJ, then through its split points in S_RUN,
// the split-point rate being set by the single pair of cost-table reads per
// cycle, then through pipeline drain and write-back in S_DRAIN. Loading
// words are taken back to back while o_in_ready is high. A chain with a
// dimension mismatch or more than 64 matrices returns an error word with
// zero cost right away. The result sits in an output register, so loading
// of the next chain can go on while it waits.
// depends on mcoc_pkg, mcoc_dim_mem, mcoc_cost_mem, mcoc_seq
module matrix_chain_order_cost_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mcoc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mcoc_pkg::t_out_word o_out_word
);

    mcoc_pkg::t_cnt      r_cnt;
    logic                r_err;
    mcoc_pkg::t_dim      r_p0;
    mcoc_pkg::t_dim      r_last_col;
    logic                r_ov;
    mcoc_pkg::t_out_word r_out;

    mcoc_pkg::t_seq_stat  seq_stat;
    mcoc_pkg::t_dim_addr  dim_raddr;
    mcoc_pkg::t_dim       dim_q;
    logic                 cost_we;
    mcoc_pkg::t_cost_addr cost_waddr;
    mcoc_pkg::t_cost      cost_wdata;
    mcoc_pkg::t_cost_addr cost_raddr_a;
    mcoc_pkg::t_cost_addr cost_raddr_b;
    mcoc_pkg::t_cost      cost_qa;
    mcoc_pkg::t_cost      cost_qb;

    logic           accept;
    logic           first;
    logic           overflow;
    logic           mismatch;
    logic           err_next;
    mcoc_pkg::t_cnt cnt_next;
    logic           dim_we;
    logic           slot_free;
    logic           take;
    logic           start;

    // input handshake
    assign slot_free  = !r_ov || i_out_ready;
    assign o_in_ready = !seq_stat.busy && (slot_free || !i_in_word.last_matrix);
    assign accept     = i_in_valid && o_in_ready;

    // chain loading
    assign first    = (r_cnt == '0);
    assign overflow = (r_cnt >= mcoc_pkg::t_cnt'(mcoc_pkg::MAX_MATRICES));
    assign mismatch = !first && !overflow && (i_in_word.row_count != r_last_col);
    assign err_next = r_err || overflow || mismatch;
    assign cnt_next = overflow ? r_cnt : r_cnt + mcoc_pkg::t_cnt'(1);
    assign dim_we   = accept && !overflow;
    assign start    = accept && i_in_word.last_matrix && !err_next;
    assign take     = seq_stat.done && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_err <= 1'b0;
        end else if (accept) begin
            r_cnt <= i_in_word.last_matrix ? '0 : cnt_next;
            r_err <= i_in_word.last_matrix ? 1'b0 : err_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dim_we) begin
            r_last_col <= i_in_word.col_count;
            if (first) begin
                r_p0 <= i_in_word.row_count;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (accept && i_in_word.last_matrix && err_next) begin
            r_ov <= 1'b1;
        end else if (take) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_word.last_matrix && err_next) begin
            r_out.min_cost    <= '0;
            r_out.chain_error <= 1'b1;
        end else if (take) begin
            r_out.min_cost    <= seq_stat.cost;
            r_out.chain_error <= 1'b0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    mcoc_dim_mem u_dim_mem (
        .i_clk   (i_clk),
        .i_we    (dim_we),
        .i_waddr (mcoc_pkg::t_dim_addr'(cnt_next)),
        .i_wdata (i_in_word.col_count),
        .i_raddr (dim_raddr),
        .o_rdata (dim_q)
    );

    mcoc_cost_mem u_cost_mem (
        .i_clk     (i_clk),
        .i_we      (cost_we),
        .i_waddr   (cost_waddr),
        .i_wdata   (cost_wdata),
        .i_raddr_a (cost_raddr_a),
        .i_raddr_b (cost_raddr_b),
        .o_rdata_a (cost_qa),
        .o_rdata_b (cost_qb)
    );

    mcoc_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_n            (cnt_next),
        .i_p0           (r_p0),
        .i_take         (take),
        .o_stat         (seq_stat),
        .o_dim_raddr    (dim_raddr),
        .i_dim_q        (dim_q),
        .o_cost_we      (cost_we),
        .o_cost_waddr   (cost_waddr),
        .o_cost_wdata   (cost_wdata),
        .o_cost_raddr_a (cost_raddr_a),
        .o_cost_raddr_b (cost_raddr_b),
        .i_cost_qa      (cost_qa),
        .i_cost_qb      (cost_qb)
    );

    // no input taken while the table fill runs
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_stat.busy |-> !o_in_ready)
        else $error("input taken during table fill");

    // error words carry zero cost
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.chain_error) |-> (o_out_word.min_cost == '0))
        else $error("error word with nonzero cost");

    // chain count stays within the dimension store
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mcoc_pkg::t_cnt'(mcoc_pkg::MAX_MATRICES))
        else $error("chain count out of range");

endmodule

/* test/testbench.sv */
// self-checking testbench for matrix_chain_order_cost_core: random and directed chains
// predicts each chain cost with its own interval table; depends on mcoc_pkg and the rtl
module testbench;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned ITEM_GOAL   = 850;
    localparam int unsigned DRAIN_WAIT  = 60;

    // chain cost predictor and pending result store
    class chain_scoreboard;
        logic [15:0] dims[mcoc_pkg::MAX_MATRICES + 1];
        logic [55:0] span_cost[mcoc_pkg::MAX_MATRICES][mcoc_pkg::MAX_MATRICES];
        int unsigned held;
        bit          bad_chain;
        mcoc_pkg::t_out_word pending[$];
        int unsigned fails;

        function new();
            held      = 0;
            bad_chain = 0;
            fails     = 0;
        endfunction

        task report(input string what, input logic [63:0] got, input logic [63:0] want);
            fails++;
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        endtask

        function logic [55:0] add_clip(input logic [63:0] a, input logic [63:0] b);
            logic [63:0] s;
            s = a + b;
            return (s > {8'h0, {56{1'b1}}}) ? {56{1'b1}} : s[55:0];
        endfunction

        // interval recurrence over every split point
        function logic [55:0] best_order(input int unsigned n);
            logic [63:0] prod;
            logic [55:0] best, c;
            int unsigned j;
            for (int unsigned i = 0; i < n; i++) span_cost[i][i] = '0;
            for (int unsigned len = 2; len <= n; len++) begin
                for (int unsigned i = 0; i + len <= n; i++) begin
                    j = i + len - 1;
                    best = {56{1'b1}};
                    for (int unsigned k = i; k < j; k++) begin
                        prod = 64'(dims[i]) * 64'(dims[k + 1]) * 64'(dims[j + 1]);
                        c = add_clip(64'(add_clip(64'(span_cost[i][k]),
                                                  64'(span_cost[k + 1][j]))), prod);
                        if (c < best) best = c;
                    end
                    span_cost[i][j] = best;
                end
            end
            return span_cost[0][n - 1];
        endfunction

        function void note_word(input mcoc_pkg::t_in_word w);
            mcoc_pkg::t_out_word r;
            if (held == 0) begin
                dims[0] = w.row_count;
                dims[1] = w.col_count;
                held = 1;
            end else if (held >= mcoc_pkg::MAX_MATRICES) begin
                bad_chain = 1;
            end else begin
                if (w.row_count != dims[held]) bad_chain = 1;
                dims[held + 1] = w.col_count;
                held++;
            end
            if (w.last_matrix) begin
                r.chain_error = bad_chain;
                r.min_cost    = bad_chain ? '0 : best_order(held);
                pending = {pending, r};
                held      = 0;
                bad_chain = 0;
            end
        endfunction

        task check_word(input mcoc_pkg::t_out_word got);
            mcoc_pkg::t_out_word want;
            if (pending.size() == 0) begin
                report("unexpected result word", 64'(got.min_cost), 0);
            end else begin
                want = pending.pop_front();
                if (got.min_cost != want.min_cost)
                    report("min_cost", 64'(got.min_cost), 64'(want.min_cost));
                if (got.chain_error != want.chain_error)
                    report("chain_error", 64'(got.chain_error), 64'(want.chain_error));
            end
        endtask
    endclass

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_in_valid = 0;
    logic                o_in_ready;
    mcoc_pkg::t_in_word  i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_ready = 0;
    mcoc_pkg::t_out_word o_out_word;

    chain_scoreboard sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycles = 0;
    int unsigned words_sent = 0;

    matrix_chain_order_cost_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result side: words that the coming edge accepts, sampled while stable
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_word(o_out_word);
    end

    // result side: random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one word, with random idle cycles ahead of it
    task send_word(input logic [15:0] rows, input logic [15:0] cols, input bit last);
        mcoc_pkg::t_in_word w;
        w.row_count   = rows;
        w.col_count   = cols;
        w.last_matrix = last;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        // ready is stable between the falling and the next rising edge
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_word(w);
        words_sent++;
    endtask

    function logic [15:0] pick_dim();
        case ($urandom_range(3))
            0: return 16'($urandom_range(1, 65535));
            1: return 16'($urandom_range(1, 30));
            2: return 16'($urandom_range(100, 2000));
            default: return $urandom_range(19) == 0 ? 16'h0 : 16'($urandom);
        endcase
    endfunction

    // chain of n matrices, links broken now and then
    task send_chain(input int unsigned n, input int unsigned break_pct);
        logic [15:0] rows, cols;
        rows = pick_dim();
        for (int unsigned m = 0; m < n; m++) begin
            cols = pick_dim();
            send_word(rows, cols, m == n - 1);
            rows = ($urandom_range(99) < break_pct) ? rows ^ 16'($urandom_range(1, 65535))
                                                    : cols;
        end
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        int unsigned phase_goal;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single matrices, extremes, mismatch, zero dims
        send_word(16'hffff, 16'hffff, 1);
        send_word(16'h0001, 16'h0001, 1);
        send_word(16'hffff, 16'hffff, 0);
        send_word(16'hffff, 16'hffff, 0);
        send_word(16'hffff, 16'hffff, 1);
        send_word(16'd10, 16'd30, 0);
        send_word(16'd30, 16'd5, 0);
        send_word(16'd5, 16'd60, 1);
        send_word(16'd10, 16'd20, 0);
        send_word(16'd21, 16'd5, 1);
        send_word(16'h0000, 16'h0000, 1);
        send_word(16'h0000, 16'h8000, 0);
        send_word(16'h8000, 16'h0000, 1);
        send_word(16'h5555, 16'haaaa, 0);
        send_word(16'haaaa, 16'h5555, 0);
        send_word(16'h1234, 16'h0001, 1);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 35 : 0;
            phase_goal = words_sent + ITEM_GOAL / 3;
            // one full-length and one overlong chain per phase
            send_chain(mcoc_pkg::MAX_MATRICES, 0);
            send_chain(mcoc_pkg::MAX_MATRICES + 1 + $urandom_range(2), 0);
            while (words_sent < phase_goal)
                send_chain($urandom_range(1, 8), $urandom_range(99) < 15 ? 30 : 0);
            wait_drained();
        end

        if (sb.fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
